// ----- hw/rtl/cbps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbps_pkg: shared types and constants of the cubic Bezier point sampler
// Field widths, register indexes and the structs that travel between the
// sequencer, the Bernstein/rotation datapath and the rounding divider.
// ----------------------------------------------------------------------------
package cbps_pkg;

  // Field widths
  localparam int unsigned PW     = 12;  // control point coordinate
  localparam int unsigned TW     = 16;  // cosine, sine, scale
  localparam int unsigned SW     = 6;   // step count and point index
  localparam int unsigned OW     = 16;  // Q12.4 output coordinate
  localparam int unsigned FRAC_W = 4;   // fraction bits of the output
  localparam int unsigned CFG_W  = 12;  // widest configuration register
  localparam int unsigned CFG_IW = 2;   // register index width

  // Datapath widths
  localparam int unsigned WW     = 18;          // Bernstein weight, up to 63^3
  localparam int unsigned BW     = 30;          // Bernstein sum, |B| <= 2048*s^3
  localparam int unsigned CW     = 32;          // trig times scale
  localparam int unsigned CSPLIT = CW / 2;      // split point of the wide multiply
  localparam int unsigned PPW    = 47;          // partial product
  localparam int unsigned RW     = 62;          // rotated numerator
  localparam int unsigned DEN_SH = 24;          // power of two in the divisor
  localparam int unsigned RND_SH = DEN_SH - 1;  // half divisor shift
  localparam int unsigned DW     = RW - DEN_SH; // dividend after the 2^24 step
  localparam int unsigned QW     = 20;          // quotient bits
  localparam int unsigned NLANE  = 2;           // x and y

  // Stream widths
  localparam int unsigned IN_DW  = 8 * PW + 3 * TW;
  localparam int unsigned OUT_DW = 2 * OW;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_POINT_STEPS = 2'd0;
  localparam logic [CFG_IW-1:0] REG_CENTER_X    = 2'd1;
  localparam logic [CFG_IW-1:0] REG_CENTER_Y    = 2'd2;

  localparam logic [SW-1:0] STEPS_RESET = 6'd8;

  typedef logic signed [PW-1:0] coord_t;

  // Point sample flags that run alongside the data
  typedef struct packed {
    logic vld;
    logic last_pt;
    logic eoc;
  } tag_t;

  // Geometry of one segment
  typedef struct packed {
    coord_t [3:0]          px;
    coord_t [3:0]          py;
    logic signed [TW-1:0]  ca;
    logic signed [TW-1:0]  sa;
    logic [TW-1:0]         sc;
  } pnt_t;

  typedef struct packed {
    pnt_t pnt;
    logic last_seg;
  } seg_t;

  // One point job leaving the sequencer
  typedef struct packed {
    tag_t          tag;
    logic [SW-1:0] idx;
    logic [SW-1:0] inv_idx;
    pnt_t          pnt;
  } job_t;

  // Rotated numerators before the divide
  typedef struct packed {
    tag_t                 tag;
    logic signed [RW-1:0] rx;
    logic signed [RW-1:0] ry;
  } rot_t;

  // Final point
  typedef struct packed {
    tag_t          tag;
    logic [OW-1:0] x;
    logic [OW-1:0] y;
  } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cbps_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbps_seq: segment sequencer
// Holds one segment; issues one point job per advancing cycle, i = 0..steps.
// ----------------------------------------------------------------------------
module cbps_seq (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    adv_i,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire cbps_pkg::seg_t          seg_i,
  input  wire logic [cbps_pkg::SW-1:0] steps_i,
  output cbps_pkg::job_t               job_o
);
  import cbps_pkg::*;

  logic          busy_r;
  logic [SW-1:0] idx_r;
  seg_t          seg_r;
  tag_t          tag_r;
  logic [SW-1:0] idx0_r;
  logic [SW-1:0] inv0_r;
  pnt_t          pnt0_r;
  logic          issue;
  logic          last_issue;
  logic          accept;

  // Issue while the pipeline moves; take a new segment on the last issue
  assign issue      = busy_r && adv_i;
  assign last_issue = issue && (idx_r >= steps_i);
  assign in_ready   = !busy_r || last_issue;
  assign accept     = in_valid && in_ready;

  // Advance the point index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (accept) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (last_issue) begin
      busy_r <= 1'b0;
    end else if (issue) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // Hold the segment
  always_ff @(posedge clk) begin
    if (accept) begin
      seg_r <= seg_i;
    end
  end

  // Job flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (adv_i) begin
      tag_r <= '{vld: issue, last_pt: last_issue, eoc: last_issue && seg_r.last_seg};
    end
  end

  // Job payload
  always_ff @(posedge clk) begin
    if (adv_i) begin
      idx0_r <= idx_r;
      inv0_r <= steps_i - idx_r;
      pnt0_r <= seg_r.pnt;
    end
  end

  assign job_o = '{tag: tag_r, idx: idx0_r, inv_idx: inv0_r, pnt: pnt0_r};

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("sequencer not busy after taking a segment");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    last_issue && !accept |=> !busy_r)
    else $error("sequencer still busy after its last point");
  a_eoc_last: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r.eoc |-> tag_r.last_pt && tag_r.vld)
    else $error("end of curve on a point that is not the last");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/cbps_bern.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbps_bern: Bernstein weights, curve sum and scaled rotation
// Seven register stages from point index to rotated numerators Rx, Ry.
// ----------------------------------------------------------------------------
module cbps_bern (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv_i,
  input  wire cbps_pkg::job_t job_i,
  output cbps_pkg::rot_t      rot_o
);
  import cbps_pkg::*;

  localparam int unsigned NST = 7;

  tag_t tag_r [NST];

  // Stage 1: squares and trig times scale
  logic [SW-1:0]        idx1_r, inv1_r;
  logic [2*SW-1:0]      sqi1_r, squ1_r;
  coord_t [3:0]         px1_r, py1_r;
  logic signed [CW-1:0] cc1_r, ss1_r;
  logic signed [CW:0]   cc_full, ss_full;

  // Stage 2: weights
  logic [WW-1:0]        w_nxt [4];
  logic [WW-1:0]        w2_r  [4];
  logic [WW-1:0]        m_ui, m_iu;
  coord_t [3:0]         px2_r, py2_r;
  logic signed [CW-1:0] cc2_r, ss2_r;

  // Stage 3: weighted coordinates
  logic signed [WW+PW:0] pxp [4];
  logic signed [WW+PW:0] pyp [4];
  logic signed [BW-1:0]  wx3_r [4];
  logic signed [BW-1:0]  wy3_r [4];
  logic signed [CW-1:0]  cc3_r, ss3_r;

  // Stage 4: curve sums
  logic signed [BW-1:0] bx4_r, by4_r;
  logic signed [CW-1:0] cc4_r, ss4_r;

  // Stage 5: partial products, order bx*cc, by*ss, bx*ss, by*cc
  logic signed [BW-1:0]     opa [4];
  logic signed [CW-1:0]     opb [4];
  logic signed [PPW-1:0]    pph [4];
  logic signed [PPW-1:0]    ppl [4];
  logic signed [PPW-1:0]    pph5_r [4];
  logic signed [PPW-1:0]    ppl5_r [4];

  // Stage 6: full products
  logic signed [RW-1:0] hi_e [4];
  logic signed [RW-1:0] lo_e [4];
  logic signed [RW-1:0] fp6_r [4];

  // Stage 7: rotation
  logic signed [RW-1:0] rx7_r, ry7_r;

  // Flags follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) tag_r[k] <= '0;
    end else if (adv_i) begin
      tag_r[0] <= job_i.tag;
      for (int k = 1; k < NST; k++) tag_r[k] <= tag_r[k-1];
    end
  end

  // Stage 1
  assign cc_full = job_i.pnt.ca * $signed({1'b0, job_i.pnt.sc});
  assign ss_full = job_i.pnt.sa * $signed({1'b0, job_i.pnt.sc});

  always_ff @(posedge clk) begin
    if (adv_i) begin
      idx1_r <= job_i.idx;
      inv1_r <= job_i.inv_idx;
      sqi1_r <= (2*SW)'(job_i.idx) * (2*SW)'(job_i.idx);
      squ1_r <= (2*SW)'(job_i.inv_idx) * (2*SW)'(job_i.inv_idx);
      px1_r  <= job_i.pnt.px;
      py1_r  <= job_i.pnt.py;
      cc1_r  <= cc_full[CW-1:0];
      ss1_r  <= ss_full[CW-1:0];
    end
  end

  // Stage 2: u^3, 3u^2 i, 3u i^2, i^3
  assign m_ui = WW'(squ1_r) * WW'(idx1_r);
  assign m_iu = WW'(sqi1_r) * WW'(inv1_r);

  always_comb begin
    w_nxt[0] = WW'(squ1_r) * WW'(inv1_r);
    w_nxt[1] = m_ui + (m_ui << 1);
    w_nxt[2] = m_iu + (m_iu << 1);
    w_nxt[3] = WW'(sqi1_r) * WW'(idx1_r);
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      for (int k = 0; k < 4; k++) w2_r[k] <= w_nxt[k];
      px2_r <= px1_r;
      py2_r <= py1_r;
      cc2_r <= cc1_r;
      ss2_r <= ss1_r;
    end
  end

  // Stage 3
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pxp[k] = $signed({1'b0, w2_r[k]}) * $signed(px2_r[k]);
      pyp[k] = $signed({1'b0, w2_r[k]}) * $signed(py2_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      for (int k = 0; k < 4; k++) begin
        wx3_r[k] <= pxp[k][BW-1:0];
        wy3_r[k] <= pyp[k][BW-1:0];
      end
      cc3_r <= cc2_r;
      ss3_r <= ss2_r;
    end
  end

  // Stage 4: sums fit the width, so wrapping adds are exact
  always_ff @(posedge clk) begin
    if (adv_i) begin
      bx4_r <= wx3_r[0] + wx3_r[1] + wx3_r[2] + wx3_r[3];
      by4_r <= wy3_r[0] + wy3_r[1] + wy3_r[2] + wy3_r[3];
      cc4_r <= cc3_r;
      ss4_r <= ss3_r;
    end
  end

  // Stage 5: split the trig term into a signed high and an unsigned low half
  always_comb begin
    opa[0] = bx4_r;  opb[0] = cc4_r;
    opa[1] = by4_r;  opb[1] = ss4_r;
    opa[2] = bx4_r;  opb[2] = ss4_r;
    opa[3] = by4_r;  opb[3] = cc4_r;
    for (int k = 0; k < 4; k++) begin
      pph[k] = opa[k] * $signed(opb[k][CW-1:CSPLIT]);
      ppl[k] = opa[k] * $signed({1'b0, opb[k][CSPLIT-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      for (int k = 0; k < 4; k++) begin
        pph5_r[k] <= pph[k];
        ppl5_r[k] <= ppl[k];
      end
    end
  end

  // Stage 6: recombine halves
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hi_e[k] = pph5_r[k];
      lo_e[k] = ppl5_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      for (int k = 0; k < 4; k++) fp6_r[k] <= (hi_e[k] <<< CSPLIT) + lo_e[k];
    end
  end

  // Stage 7: rotate
  always_ff @(posedge clk) begin
    if (adv_i) begin
      rx7_r <= fp6_r[0] - fp6_r[1];
      ry7_r <= fp6_r[2] + fp6_r[3];
    end
  end

  assign rot_o = '{tag: tag_r[NST-1], rx: rx7_r, ry: ry7_r};

endmodule
`default_nettype wire

// ----- hw/rtl/cbps_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbps_div: rounding divide by steps^3 * 2^24, centre offset and saturation
// Sign-magnitude rounding (ties away from zero), then a restoring divider
// with one quotient bit per stage, for x and y side by side.
// ----------------------------------------------------------------------------
module cbps_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv_i,
  input  wire cbps_pkg::rot_t             rot_i,
  input  wire logic [cbps_pkg::WW-1:0]    s3_i,
  input  wire logic [cbps_pkg::CFG_W-1:0] center_x_i,
  input  wire logic [cbps_pkg::CFG_W-1:0] center_y_i,
  output cbps_pkg::res_t                  res_o
);
  import cbps_pkg::*;

  localparam int unsigned SUMW = QW + 2;

  logic [RW-1:0]    num    [NLANE];
  logic [OW-1:0]    off    [NLANE];

  // Stage A: magnitude
  tag_t             tag_a_r;
  logic             neg_a_r [NLANE];
  logic [RW-2:0]    mag_a_r [NLANE];
  logic [RW-1:0]    mag_w   [NLANE];

  // Stage B and divider stages
  logic [RW-1:0]    biased  [NLANE];
  logic [DW-1:0]    trial   [QW];
  tag_t             tagd_r  [QW+1];
  logic             negd_r  [QW+1][NLANE];
  logic [DW-1:0]    remd_r  [QW+1][NLANE];
  logic [QW-1:0]    quod_r  [QW+1][NLANE];

  // Stage E: sign and offset
  tag_t             tag_e_r;
  logic [QW:0]      qx      [NLANE];
  logic [QW:0]      qs      [NLANE];
  logic [SUMW-1:0]  sum_e_r [NLANE];

  // Stage F: saturate
  tag_t             tag_f_r;
  logic [OW-1:0]    sat     [NLANE];
  logic [OW-1:0]    out_f_r [NLANE];

  assign num[0] = rot_i.rx;
  assign num[1] = rot_i.ry;
  assign off[0] = {center_x_i, {FRAC_W{1'b0}}};
  assign off[1] = {center_y_i, {FRAC_W{1'b0}}};

  // Flags follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      for (int g = 0; g <= QW; g++) tagd_r[g] <= '0;
      tag_e_r <= '0;
      tag_f_r <= '0;
    end else if (adv_i) begin
      tag_a_r   <= rot_i.tag;
      tagd_r[0] <= tag_a_r;
      for (int g = 1; g <= QW; g++) tagd_r[g] <= tagd_r[g-1];
      tag_e_r   <= tagd_r[QW];
      tag_f_r   <= tag_e_r;
    end
  end

  // Magnitude and half-divisor bias, floor by 2^24 first
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      mag_w[l]  = num[l][RW-1] ? (RW'(0) - num[l]) : num[l];
      biased[l] = RW'(mag_a_r[l]) + (RW'(s3_i) << RND_SH);
    end
  end

  // Shifted divisor for each quotient bit
  always_comb begin
    for (int g = 0; g < QW; g++) trial[g] = DW'(s3_i) << (QW - 1 - g);
  end

  // Sign and offset
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      qx[l] = {1'b0, quod_r[QW][l]};
      qs[l] = negd_r[QW][l] ? ((QW+1)'(0) - qx[l]) : qx[l];
    end
  end

  // Clamp to the 16 bit signed range
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      if ((sum_e_r[l][SUMW-1:OW-1] == '0) || (sum_e_r[l][SUMW-1:OW-1] == '1)) begin
        sat[l] = sum_e_r[l][OW-1:0];
      end else if (sum_e_r[l][SUMW-1]) begin
        sat[l] = {1'b1, {(OW-1){1'b0}}};
      end else begin
        sat[l] = {1'b0, {(OW-1){1'b1}}};
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (adv_i) begin
      for (int l = 0; l < NLANE; l++) begin
        neg_a_r[l]   <= num[l][RW-1];
        mag_a_r[l]   <= mag_w[l][RW-2:0];
        negd_r[0][l] <= neg_a_r[l];
        remd_r[0][l] <= biased[l][RW-1:DEN_SH];
        quod_r[0][l] <= '0;
        // one restoring step per stage, most significant quotient bit first
        for (int g = 0; g < QW; g++) begin
          negd_r[g+1][l] <= negd_r[g][l];
          if (remd_r[g][l] >= trial[g]) begin
            remd_r[g+1][l] <= remd_r[g][l] - trial[g];
            quod_r[g+1][l] <= {quod_r[g][l][QW-2:0], 1'b1};
          end else begin
            remd_r[g+1][l] <= remd_r[g][l];
            quod_r[g+1][l] <= {quod_r[g][l][QW-2:0], 1'b0};
          end
        end
        sum_e_r[l] <= {qs[l][QW], qs[l]} + SUMW'(off[l]);
        out_f_r[l] <= sat[l];
      end
    end
  end

  assign res_o = '{tag: tag_f_r, x: out_f_r[0], y: out_f_r[1]};

endmodule
`default_nettype wire

// ----- hw/rtl/cubic_bezier_point_sampler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_point_sampler: sample one cubic Bezier segment into pixels
// A segment transfer yields steps+1 point transfers (nine at the reset value
// of eight steps), one per cycle while the output is taken; the next segment
// is taken in the cycle the sequencer issues the last point of the current
// one. The rate is set by the sequencer, which feeds one Bernstein sample per
// cycle, while the pipeline advances, into the weights, curve sum and scaled
// rotation stages and then a 20 stage restoring divider by steps^3 * 2^24.
// The whole pipeline holds while out_tvalid is high and out_tready is low.
// Configuration is to be written by the user only with no segment in flight;
// the block itself does not enforce it. A step count of zero runs as one.
// ----------------------------------------------------------------------------
module cubic_bezier_point_sampler (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // segment input
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, rot_cos, rot_sin, scale_factor
  input  wire logic [cbps_pkg::IN_DW-1:0]  in_tdata,
  input  wire logic                        in_tlast,   // last_segment
  // point output
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [cbps_pkg::OUT_DW-1:0]      out_tdata,  // x_pos, y_pos
  output logic                             out_tlast,  // last_point
  output logic                             out_tuser,  // end_of_curve
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [cbps_pkg::CFG_IW-1:0] cfg_idx,
  input  wire logic [cbps_pkg::CFG_W-1:0]  cfg_wdata
);
  import cbps_pkg::*;

  logic [SW-1:0]    steps_r;
  logic [CFG_W-1:0] cx_r, cy_r;
  logic [WW-1:0]    s3_r;
  logic [SW-1:0]    steps_nxt;
  logic [2*SW-1:0]  sq;
  seg_t             seg;
  job_t             job;
  rot_t             rot;
  res_t             res;
  logic             adv;

  // Configuration registers; a step count of zero is stored as one
  assign steps_nxt = (cfg_wdata[SW-1:0] == '0) ? SW'(1) : cfg_wdata[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= STEPS_RESET;
      cx_r    <= '0;
      cy_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_POINT_STEPS: steps_r <= steps_nxt;
        REG_CENTER_X:    cx_r    <= cfg_wdata;
        REG_CENTER_Y:    cy_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Divisor steps^3, settled long before a point reaches the divider
  assign sq = (2*SW)'(steps_r) * (2*SW)'(steps_r);

  always_ff @(posedge clk) begin
    s3_r <= WW'(sq) * WW'(steps_r);
  end

  // Unpack the segment
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      seg.pnt.px[k] = in_tdata[2*PW*k +: PW];
      seg.pnt.py[k] = in_tdata[2*PW*k + PW +: PW];
    end
    seg.pnt.ca   = in_tdata[8*PW +: TW];
    seg.pnt.sa   = in_tdata[8*PW + TW +: TW];
    seg.pnt.sc   = in_tdata[8*PW + 2*TW +: TW];
    seg.last_seg = in_tlast;
  end

  // Advance everything when the output register is free
  assign adv = !res.tag.vld || out_tready;

  cbps_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv_i    (adv),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .seg_i    (seg),
    .steps_i  (steps_r),
    .job_o    (job)
  );

  cbps_bern u_bern (
    .clk   (clk),
    .rst_n (rst_n),
    .adv_i (adv),
    .job_i (job),
    .rot_o (rot)
  );

  cbps_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv_i      (adv),
    .rot_i      (rot),
    .s3_i       (s3_r),
    .center_x_i (cx_r),
    .center_y_i (cy_r),
    .res_o      (res)
  );

  assign out_tvalid = res.tag.vld;
  assign out_tdata  = {res.y, res.x};
  assign out_tlast  = res.tag.last_pt;
  assign out_tuser  = res.tag.eoc;

`ifndef SYNTHESIS
  a_eoc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("end of curve without last point");
  a_steps_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r != '0)
    else $error("step count register holds zero");
  a_cube: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $stable(steps_r) |-> s3_r == WW'(sq) * WW'(steps_r))
    else $error("divisor does not match the step count");
`endif

endmodule
`default_nettype wire
